### rtl/core/tcpe_pkg.sv
// Package for the touch calibration and pen event unit.
// Holds widths, register indexes, orientation codes and the lane and merge structs.
// No dependencies; every other file takes names from here by scope.
package tcpe_pkg;

  localparam int ADC_BITS   = 10;
  localparam int RES_BITS   = 11;
  localparam int PRESS_BITS = 10;
  localparam int PROD_BITS  = ADC_BITS + RES_BITS;
  localparam int STEP_BITS  = $clog2(RES_BITS);
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = RES_BITS;

  localparam logic [CFG_IDX_BITS-1:0] REG_OFFSET_X      = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_OFFSET_Y      = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_ADC_TOP_X     = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_ADC_TOP_Y     = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_SCREEN_WIDTH  = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_SCREEN_HEIGHT = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_ORIENT_MODE   = 3'd6;

  localparam logic [1:0] ORIENT_PLAIN     = 2'd0;
  localparam logic [1:0] ORIENT_SWAP_FLIP = 2'd1;
  localparam logic [1:0] ORIENT_FLIP_Y    = 2'd2;

  localparam logic [ADC_BITS-1:0] RST_OFFSET_X      = 10'd80;
  localparam logic [ADC_BITS-1:0] RST_OFFSET_Y      = 10'd100;
  localparam logic [ADC_BITS-1:0] RST_ADC_TOP_X     = 10'd960;
  localparam logic [ADC_BITS-1:0] RST_ADC_TOP_Y     = 10'd930;
  localparam logic [RES_BITS-1:0] RST_SCREEN_WIDTH  = 11'd240;
  localparam logic [RES_BITS-1:0] RST_SCREEN_HEIGHT = 11'd320;
  localparam logic [1:0]          RST_ORIENT_MODE   = ORIENT_SWAP_FLIP;

  typedef struct packed {
    logic                start;
    logic                flip;
    logic [ADC_BITS-1:0] raw;
    logic [ADC_BITS-1:0] low;
    logic [ADC_BITS-1:0] top;
    logic [RES_BITS-1:0] res;
  } lane_req_t;

  typedef struct packed {
    logic                done;
    logic [RES_BITS-1:0] pos;
  } lane_rsp_t;

  typedef struct packed {
    logic                  load;
    logic                  release_evt;
    logic [PRESS_BITS-1:0] pressure;
  } merge_ctl_t;

endpackage

### rtl/core/tcpe_scan_if.sv
// Scan request channel: valid, ready and one panel scan.
// Depends on tcpe_pkg for field widths.
interface tcpe_scan_if;
  logic                            valid;
  logic                            ready;
  logic [tcpe_pkg::ADC_BITS-1:0]   raw_x;
  logic [tcpe_pkg::ADC_BITS-1:0]   raw_y;
  logic [tcpe_pkg::PRESS_BITS-1:0] raw_pressure;
  logic                            pen_raised;
  logic                            skip_sample;

  modport source (output valid, raw_x, raw_y, raw_pressure, pen_raised, skip_sample,
                  input ready);
  modport sink (input valid, raw_x, raw_y, raw_pressure, pen_raised, skip_sample,
                output ready);
endinterface

### rtl/core/tcpe_report_if.sv
// Report request channel: valid, ready and one pen event.
// Depends on tcpe_pkg for field widths.
interface tcpe_report_if;
  logic                            valid;
  logic                            ready;
  logic [tcpe_pkg::RES_BITS-1:0]   pos_x;
  logic [tcpe_pkg::RES_BITS-1:0]   pos_y;
  logic [tcpe_pkg::PRESS_BITS-1:0] pressure_out;
  logic                            is_release;

  modport source (output valid, pos_x, pos_y, pressure_out, is_release, input ready);
  modport sink (input valid, pos_x, pos_y, pressure_out, is_release, output ready);
endinterface

### rtl/core/tcpe_lane.sv
// One calibration lane: offset, multiply, serial restoring divide, clamp and flip.
// Depends on tcpe_pkg for widths and the lane request and response structs.
module tcpe_lane (
  input  logic                clk,
  input  logic                rst,
  input  tcpe_pkg::lane_req_t req,
  output tcpe_pkg::lane_rsp_t rsp
);

  typedef enum logic [1:0] {L_IDLE, L_MUL, L_DIV, L_FIN} lane_state_t;

  lane_state_t                       state;
  logic [tcpe_pkg::ADC_BITS-1:0]     diff;
  logic [tcpe_pkg::ADC_BITS-1:0]     span;
  logic                              span_ok;
  logic [tcpe_pkg::RES_BITS-1:0]     res;
  logic                              flip;
  logic                              sat;
  logic [tcpe_pkg::ADC_BITS-1:0]     rem;
  logic [tcpe_pkg::RES_BITS-1:0]     quo;
  logic [tcpe_pkg::STEP_BITS-1:0]    cnt;
  logic [tcpe_pkg::RES_BITS-1:0]     pos;
  logic                              done;

  logic [tcpe_pkg::PROD_BITS-1:0]    prod;
  logic [tcpe_pkg::ADC_BITS:0]       trial;
  logic                              fits;
  logic [tcpe_pkg::RES_BITS-1:0]     fin_val;
  logic [tcpe_pkg::RES_BITS-1:0]     fin_pos;

  assign prod    = tcpe_pkg::PROD_BITS'(diff) * tcpe_pkg::PROD_BITS'(res);
  assign trial   = {rem, quo[tcpe_pkg::RES_BITS-1]};
  assign fits    = trial >= {1'b0, span};
  assign fin_val = sat ? res - tcpe_pkg::RES_BITS'(1) : quo;
  assign fin_pos = flip ? res - fin_val - tcpe_pkg::RES_BITS'(1) : fin_val;

  assign rsp.done = done;
  assign rsp.pos  = pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= L_IDLE;
      done  <= 1'b0;
      cnt   <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        L_IDLE: begin
          if (req.start) begin
            diff    <= (req.raw > req.low) ? req.raw - req.low : '0;
            span    <= req.top - req.low;
            span_ok <= req.top > req.low;
            res     <= req.res;
            flip    <= req.flip;
            state   <= L_MUL;
          end
        end
        L_MUL: begin
          // A quotient at or above the resolution is the same test as diff >= span.
          sat   <= !span_ok || (res == '0) || (diff >= span);
          rem   <= prod[tcpe_pkg::PROD_BITS-1 -: tcpe_pkg::ADC_BITS];
          quo   <= prod[tcpe_pkg::RES_BITS-1:0];
          cnt   <= '0;
          state <= L_DIV;
        end
        L_DIV: begin
          rem <= fits ? tcpe_pkg::ADC_BITS'(trial - {1'b0, span})
                      : trial[tcpe_pkg::ADC_BITS-1:0];
          quo <= {quo[tcpe_pkg::RES_BITS-2:0], fits};
          cnt <= cnt + tcpe_pkg::STEP_BITS'(1);
          if (cnt == tcpe_pkg::STEP_BITS'(tcpe_pkg::RES_BITS - 1)) begin
            state <= L_FIN;
          end
        end
        L_FIN: begin
          pos   <= fin_pos;
          done  <= 1'b1;
          state <= L_IDLE;
        end
        default: begin
          state <= L_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/core/tcpe_merge.sv
// Merge stage: combines the two lane results into one event and holds it
// in the output register. Depends on tcpe_pkg and tcpe_report_if.
module tcpe_merge (
  input  logic                           clk,
  input  logic                           rst,
  input  tcpe_pkg::merge_ctl_t           ctl,
  input  logic [tcpe_pkg::RES_BITS-1:0]  lane_x_pos,
  input  logic [tcpe_pkg::RES_BITS-1:0]  lane_y_pos,
  output logic                           free,
  tcpe_report_if.source                  report
);

  assign free = !report.valid || report.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      report.valid <= 1'b0;
    end else if (free && ctl.load) begin
      report.valid        <= 1'b1;
      report.is_release   <= ctl.release_evt;
      report.pos_x        <= ctl.release_evt ? '0 : lane_x_pos;
      report.pos_y        <= ctl.release_evt ? '0 : lane_y_pos;
      report.pressure_out <= ctl.release_evt ? '0 : ctl.pressure;
    end else if (report.ready) begin
      report.valid <= 1'b0;
    end
  end

endmodule

### rtl/core/touch_calibrate_and_pen_events_unit.sv
// Touch calibration and pen event unit: top level with configuration registers and control.
// A pen-down scan runs through both lanes (two lanes, 11-step serial divide) before its event is staged;
// a release event is staged directly; the next scan is taken the cycle after the event is handed over.
// Synchronous active-high reset restores the register defaults and clears the touch flag.
// Depends on tcpe_pkg, tcpe_scan_if, tcpe_report_if, tcpe_lane and tcpe_merge.
module touch_calibrate_and_pen_events_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [tcpe_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [tcpe_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  tcpe_scan_if.sink                           scan,
  tcpe_report_if.source                       report
);

  typedef enum logic [1:0] {S_IDLE, S_BUSY, S_EMIT} top_state_t;

  top_state_t                        state;
  logic                              touch_valid;
  logic [tcpe_pkg::ADC_BITS-1:0]     offset_x;
  logic [tcpe_pkg::ADC_BITS-1:0]     offset_y;
  logic [tcpe_pkg::ADC_BITS-1:0]     adc_top_x;
  logic [tcpe_pkg::ADC_BITS-1:0]     adc_top_y;
  logic [tcpe_pkg::RES_BITS-1:0]     screen_width;
  logic [tcpe_pkg::RES_BITS-1:0]     screen_height;
  logic [1:0]                        orient_mode;
  logic                              lane_start;
  logic [tcpe_pkg::ADC_BITS-1:0]     lane_x_raw;
  logic [tcpe_pkg::ADC_BITS-1:0]     lane_y_raw;
  logic                              flip_x;
  logic                              flip_y;
  logic                              stage_release;
  logic [tcpe_pkg::PRESS_BITS-1:0]   stage_pressure;

  logic                              accept;
  logic                              swap;
  logic                              merge_free;
  tcpe_pkg::lane_req_t               req_x;
  tcpe_pkg::lane_req_t               req_y;
  tcpe_pkg::lane_rsp_t               rsp_x;
  tcpe_pkg::lane_rsp_t               rsp_y;
  tcpe_pkg::merge_ctl_t              mctl;

  assign scan.ready = (state == S_IDLE);
  assign accept     = scan.valid && scan.ready;
  assign swap       = (orient_mode == tcpe_pkg::ORIENT_SWAP_FLIP);

  assign req_x.start = lane_start;
  assign req_x.flip  = flip_x;
  assign req_x.raw   = lane_x_raw;
  assign req_x.low   = offset_x;
  assign req_x.top   = adc_top_x;
  assign req_x.res   = screen_width;

  assign req_y.start = lane_start;
  assign req_y.flip  = flip_y;
  assign req_y.raw   = lane_y_raw;
  assign req_y.low   = offset_y;
  assign req_y.top   = adc_top_y;
  assign req_y.res   = screen_height;

  assign mctl.load        = (state == S_EMIT);
  assign mctl.release_evt = stage_release;
  assign mctl.pressure    = stage_pressure;

  tcpe_lane u_lane_x (.clk(clk), .rst(rst), .req(req_x), .rsp(rsp_x));
  tcpe_lane u_lane_y (.clk(clk), .rst(rst), .req(req_y), .rsp(rsp_y));

  tcpe_merge u_merge (
    .clk        (clk),
    .rst        (rst),
    .ctl        (mctl),
    .lane_x_pos (rsp_x.pos),
    .lane_y_pos (rsp_y.pos),
    .free       (merge_free),
    .report     (report)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      touch_valid   <= 1'b0;
      lane_start    <= 1'b0;
      offset_x      <= tcpe_pkg::RST_OFFSET_X;
      offset_y      <= tcpe_pkg::RST_OFFSET_Y;
      adc_top_x     <= tcpe_pkg::RST_ADC_TOP_X;
      adc_top_y     <= tcpe_pkg::RST_ADC_TOP_Y;
      screen_width  <= tcpe_pkg::RST_SCREEN_WIDTH;
      screen_height <= tcpe_pkg::RST_SCREEN_HEIGHT;
      orient_mode   <= tcpe_pkg::RST_ORIENT_MODE;
    end else begin
      lane_start <= 1'b0;
      if (cfg_write) begin
        case (cfg_index)
          tcpe_pkg::REG_OFFSET_X:      offset_x      <= cfg_data[tcpe_pkg::ADC_BITS-1:0];
          tcpe_pkg::REG_OFFSET_Y:      offset_y      <= cfg_data[tcpe_pkg::ADC_BITS-1:0];
          tcpe_pkg::REG_ADC_TOP_X:     adc_top_x     <= cfg_data[tcpe_pkg::ADC_BITS-1:0];
          tcpe_pkg::REG_ADC_TOP_Y:     adc_top_y     <= cfg_data[tcpe_pkg::ADC_BITS-1:0];
          tcpe_pkg::REG_SCREEN_WIDTH:  screen_width  <= cfg_data;
          tcpe_pkg::REG_SCREEN_HEIGHT: screen_height <= cfg_data;
          tcpe_pkg::REG_ORIENT_MODE:   orient_mode   <= cfg_data[1:0];
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (scan.pen_raised) begin
              if (touch_valid) begin
                touch_valid    <= 1'b0;
                stage_release  <= 1'b1;
                stage_pressure <= '0;
                state          <= S_EMIT;
              end
            end else if (!scan.skip_sample) begin
              lane_x_raw     <= swap ? scan.raw_y : scan.raw_x;
              lane_y_raw     <= swap ? scan.raw_x : scan.raw_y;
              flip_x         <= swap;
              flip_y         <= swap || (orient_mode == tcpe_pkg::ORIENT_FLIP_Y);
              lane_start     <= 1'b1;
              stage_release  <= 1'b0;
              stage_pressure <= scan.raw_pressure;
              touch_valid    <= 1'b1;
              state          <= S_BUSY;
            end
          end
        end
        S_BUSY: begin
          if (rsp_x.done) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (merge_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_lanes_in_step: assert property (@(posedge clk) disable iff (rst)
    rsp_x.done == rsp_y.done)
    else $error("lane completions are out of step");

  a_done_only_busy: assert property (@(posedge clk) disable iff (rst)
    rsp_x.done |-> state == S_BUSY)
    else $error("lane finished outside a busy period");

  a_touch_set: assert property (@(posedge clk) disable iff (rst)
    accept && !scan.pen_raised && !scan.skip_sample |=> touch_valid && state == S_BUSY)
    else $error("pen-down scan did not start the lanes and set the touch flag");

  a_release_clear: assert property (@(posedge clk) disable iff (rst)
    accept && scan.pen_raised |=> !touch_valid)
    else $error("touch flag still set after pen raise");

  a_release_event: assert property (@(posedge clk) disable iff (rst)
    accept && scan.pen_raised && touch_valid |=> state == S_EMIT && stage_release)
    else $error("release request not staged");

endmodule

### test/touch_calibrate_and_pen_events_unit_tb.sv
// Testbench for the touch calibration and pen event unit: a directed table, then random strokes
// over many register settings; each event is checked against a typed value or an in-bench calibrator.
// Depends on tcpe_pkg, tcpe_scan_if, tcpe_report_if and the unit itself.
module touch_calibrate_and_pen_events_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0]                    ORIENT_PLAIN_ALT = 2'd3;
  localparam logic [tcpe_pkg::ADC_BITS-1:0] ADC_MAX          = '1;
  localparam logic [tcpe_pkg::RES_BITS-1:0] RES_MAX          = '1;
  localparam int SETTLE_CYCLES    = 40;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int RANDOM_PHASES    = 13;
  localparam int ITEMS_PER_PHASE  = 150;
  localparam int MAX_PRINTS       = 100;

  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_EVENT} check_kind_t;
  typedef enum logic {ROW_SCAN, ROW_CFG} row_kind_t;

  typedef struct packed {
    logic [tcpe_pkg::ADC_BITS-1:0]   raw_x;
    logic [tcpe_pkg::ADC_BITS-1:0]   raw_y;
    logic [tcpe_pkg::PRESS_BITS-1:0] raw_pressure;
    logic                            pen_raised;
    logic                            skip_sample;
  } scan_t;

  typedef struct packed {
    logic [tcpe_pkg::RES_BITS-1:0]   pos_x;
    logic [tcpe_pkg::RES_BITS-1:0]   pos_y;
    logic [tcpe_pkg::PRESS_BITS-1:0] pressure_out;
    logic                            is_release;
  } pen_event_t;

  typedef struct {
    row_kind_t                          kind;
    logic [tcpe_pkg::CFG_IDX_BITS-1:0]  idx;
    logic [tcpe_pkg::CFG_DATA_BITS-1:0] data;
    scan_t                              scan;
    check_kind_t                        chk;
    pen_event_t                         typed;
  } stim_row_t;

  logic                               clk = 1'b0;
  logic                               rst;
  logic                               cfg_write;
  logic [tcpe_pkg::CFG_IDX_BITS-1:0]  cfg_index;
  logic [tcpe_pkg::CFG_DATA_BITS-1:0] cfg_data;

  tcpe_scan_if   scan_ch ();
  tcpe_report_if report_ch ();

  touch_calibrate_and_pen_events_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .scan      (scan_ch),
    .report    (report_ch)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  logic [tcpe_pkg::ADC_BITS-1:0] cal_off_x, cal_off_y, cal_top_x, cal_top_y;
  logic [tcpe_pkg::RES_BITS-1:0] cal_width, cal_height;
  logic [1:0]                    cal_mode;
  logic                          cal_touch_valid;

  pen_event_t pending_events[$];
  stim_row_t  stim_rows[$];
  int         error_count = 0;
  int         send_idle_pct = 11;
  int         recv_idle_pct = 56;
  int         hold_left = 0;
  bit         long_hold_req = 0;
  bit         cfg_busy = 0;

  task automatic report_error(input string msg);
    if (error_count < MAX_PRINTS) $display("ERROR at %0t ns: %s", $time, msg);
    error_count++;
  endtask

  function automatic logic [tcpe_pkg::RES_BITS-1:0] scale_to_screen(
      input logic [tcpe_pkg::ADC_BITS-1:0] raw,
      input logic [tcpe_pkg::ADC_BITS-1:0] low,
      input logic [tcpe_pkg::ADC_BITS-1:0] top,
      input logic [tcpe_pkg::RES_BITS-1:0] res);
    int unsigned diff;
    int unsigned q;
    diff = (raw > low) ? int'(raw) - int'(low) : 0;
    if (top <= low) return res - 1'b1;
    q = (diff * res) / (int'(top) - int'(low));
    if (q >= res) return res - 1'b1;
    return q[tcpe_pkg::RES_BITS-1:0];
  endfunction

  function automatic bit calibrate_scan(input scan_t s, output pen_event_t ev);
    logic [tcpe_pkg::ADC_BITS-1:0] ax, ay;
    logic [tcpe_pkg::RES_BITS-1:0] px, py;
    ev = '0;
    if (s.pen_raised) begin
      if (!cal_touch_valid) return 1'b0;
      cal_touch_valid = 1'b0;
      ev.is_release = 1'b1;
      return 1'b1;
    end
    if (s.skip_sample) return 1'b0;
    ax = s.raw_x;
    ay = s.raw_y;
    if (cal_mode == tcpe_pkg::ORIENT_SWAP_FLIP) begin
      ax = s.raw_y;
      ay = s.raw_x;
    end
    px = scale_to_screen(ax, cal_off_x, cal_top_x, cal_width);
    py = scale_to_screen(ay, cal_off_y, cal_top_y, cal_height);
    if (cal_mode == tcpe_pkg::ORIENT_SWAP_FLIP) begin
      px = cal_width - px - 1'b1;
      py = cal_height - py - 1'b1;
    end else if (cal_mode == tcpe_pkg::ORIENT_FLIP_Y) begin
      py = cal_height - py - 1'b1;
    end
    cal_touch_valid = 1'b1;
    ev.pos_x = px;
    ev.pos_y = py;
    ev.pressure_out = s.raw_pressure;
    return 1'b1;
  endfunction

  function automatic void apply_reg(input logic [tcpe_pkg::CFG_IDX_BITS-1:0] idx,
                                    input logic [tcpe_pkg::CFG_DATA_BITS-1:0] data);
    case (idx)
      tcpe_pkg::REG_OFFSET_X:      cal_off_x  = data[tcpe_pkg::ADC_BITS-1:0];
      tcpe_pkg::REG_OFFSET_Y:      cal_off_y  = data[tcpe_pkg::ADC_BITS-1:0];
      tcpe_pkg::REG_ADC_TOP_X:     cal_top_x  = data[tcpe_pkg::ADC_BITS-1:0];
      tcpe_pkg::REG_ADC_TOP_Y:     cal_top_y  = data[tcpe_pkg::ADC_BITS-1:0];
      tcpe_pkg::REG_SCREEN_WIDTH:  cal_width  = data[tcpe_pkg::RES_BITS-1:0];
      tcpe_pkg::REG_SCREEN_HEIGHT: cal_height = data[tcpe_pkg::RES_BITS-1:0];
      tcpe_pkg::REG_ORIENT_MODE:   cal_mode   = data[1:0];
      default: ;
    endcase
  endfunction

  function automatic void add_cfg(input logic [tcpe_pkg::CFG_IDX_BITS-1:0] idx,
                                  input logic [tcpe_pkg::CFG_DATA_BITS-1:0] data);
    stim_row_t r;
    r.kind = ROW_CFG;
    r.idx = idx;
    r.data = data;
    r.scan = '0;
    r.chk = CHK_NONE;
    r.typed = '0;
    stim_rows.push_back(r);
  endfunction

  function automatic void add_scan(input logic [tcpe_pkg::ADC_BITS-1:0] rx,
                                   input logic [tcpe_pkg::ADC_BITS-1:0] ry,
                                   input logic [tcpe_pkg::PRESS_BITS-1:0] rp, input logic raised,
                                   input logic skip, input check_kind_t chk,
                                   input logic [tcpe_pkg::RES_BITS-1:0] ex,
                                   input logic [tcpe_pkg::RES_BITS-1:0] ey,
                                   input logic [tcpe_pkg::PRESS_BITS-1:0] ep, input logic erel);
    stim_row_t r;
    r.kind = ROW_SCAN;
    r.idx = '0;
    r.data = '0;
    r.scan.raw_x = rx;
    r.scan.raw_y = ry;
    r.scan.raw_pressure = rp;
    r.scan.pen_raised = raised;
    r.scan.skip_sample = skip;
    r.chk = chk;
    r.typed.pos_x = ex;
    r.typed.pos_y = ey;
    r.typed.pressure_out = ep;
    r.typed.is_release = erel;
    stim_rows.push_back(r);
  endfunction

  function automatic logic [tcpe_pkg::ADC_BITS-1:0] pick_edge(input bit high_edge,
                                                              input bit extremes);
    int r;
    r = $urandom_range(0, 19);
    if (extremes) begin
      if (r < 14) return high_edge ? ADC_MAX : '0;
      return tcpe_pkg::ADC_BITS'($urandom_range(0, 1023));
    end
    if (r < 2) return tcpe_pkg::ADC_BITS'($urandom_range(0, 1023));
    return high_edge ? tcpe_pkg::ADC_BITS'($urandom_range(600, 1023))
                     : tcpe_pkg::ADC_BITS'($urandom_range(0, 400));
  endfunction

  function automatic logic [tcpe_pkg::RES_BITS-1:0] pick_res(input bit extremes);
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (extremes) return (r < 10) ? RES_MAX : 11'd1;
    if (r < 6) return tcpe_pkg::RES_BITS'($urandom_range(1, 64));
    return tcpe_pkg::RES_BITS'($urandom_range(1, 2047));
  endfunction

  function automatic logic [tcpe_pkg::ADC_BITS-1:0] pick_sample();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return ADC_MAX;
    return tcpe_pkg::ADC_BITS'($urandom_range(0, 1023));
  endfunction

  task automatic wait_idle();
    scan_ch.valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [tcpe_pkg::CFG_IDX_BITS-1:0] idx,
                           input logic [tcpe_pkg::CFG_DATA_BITS-1:0] data);
    if (!cfg_busy) wait_idle();
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    apply_reg(idx, data);
    cfg_busy = 1'b1;
  endtask

  task automatic random_setup(input int phase);
    bit extremes;
    extremes = (phase % 4 == 0);
    write_reg(tcpe_pkg::REG_OFFSET_X,
              tcpe_pkg::CFG_DATA_BITS'(pick_edge(1'b0, extremes)));
    write_reg(tcpe_pkg::REG_OFFSET_Y,
              tcpe_pkg::CFG_DATA_BITS'(pick_edge(1'b0, extremes)));
    write_reg(tcpe_pkg::REG_ADC_TOP_X,
              tcpe_pkg::CFG_DATA_BITS'(pick_edge(1'b1, extremes)));
    write_reg(tcpe_pkg::REG_ADC_TOP_Y,
              tcpe_pkg::CFG_DATA_BITS'(pick_edge(1'b1, extremes)));
    write_reg(tcpe_pkg::REG_SCREEN_WIDTH, pick_res(extremes));
    write_reg(tcpe_pkg::REG_SCREEN_HEIGHT, pick_res(extremes));
    write_reg(tcpe_pkg::REG_ORIENT_MODE, tcpe_pkg::CFG_DATA_BITS'($urandom_range(0, 3)));
  endtask

  task automatic send_scan(input scan_t s, input check_kind_t chk, input pen_event_t typed);
    pen_event_t ev;
    bit has_event;
    if (cfg_busy) begin
      cfg_write <= 1'b0;
      cfg_busy = 1'b0;
    end
    if ($urandom_range(99) < send_idle_pct) begin
      scan_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    scan_ch.valid        <= 1'b1;
    scan_ch.raw_x        <= s.raw_x;
    scan_ch.raw_y        <= s.raw_y;
    scan_ch.raw_pressure <= s.raw_pressure;
    scan_ch.pen_raised   <= s.pen_raised;
    scan_ch.skip_sample  <= s.skip_sample;
    do @(posedge clk); while (!scan_ch.ready);
    has_event = calibrate_scan(s, ev);
    case (chk)
      CHK_MODEL: if (has_event) pending_events.push_back(ev);
      CHK_EVENT: pending_events.push_back(typed);
      default: ;
    endcase
  endtask

  initial begin
    report_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        hold_left = LONG_HOLD_CYCLES;
        long_hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        report_ch.ready <= 1'b0;
      end else begin
        report_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    pen_event_t got, want;
    if (!rst && report_ch.valid && report_ch.ready) begin
      got.pos_x = report_ch.pos_x;
      got.pos_y = report_ch.pos_y;
      got.pressure_out = report_ch.pressure_out;
      got.is_release = report_ch.is_release;
      if (pending_events.size() == 0) begin
        report_error($sformatf("event with none pending: %p", got));
      end else begin
        want = pending_events.pop_front();
        if (got.pos_x !== want.pos_x)
          report_error($sformatf("pos_x got %0d expected %0d", got.pos_x, want.pos_x));
        if (got.pos_y !== want.pos_y)
          report_error($sformatf("pos_y got %0d expected %0d", got.pos_y, want.pos_y));
        if (got.pressure_out !== want.pressure_out)
          report_error($sformatf("pressure_out got %0d expected %0d",
                                 got.pressure_out, want.pressure_out));
        if (got.is_release !== want.is_release)
          report_error($sformatf("is_release got %0d expected %0d",
                                 got.is_release, want.is_release));
      end
    end
  end

  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    scan_t s;
    int stroke_left;
    int regime;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    scan_ch.valid = 1'b0;
    scan_ch.raw_x = '0;
    scan_ch.raw_y = '0;
    scan_ch.raw_pressure = '0;
    scan_ch.pen_raised = 1'b0;
    scan_ch.skip_sample = 1'b0;
    cal_off_x = tcpe_pkg::RST_OFFSET_X;
    cal_off_y = tcpe_pkg::RST_OFFSET_Y;
    cal_top_x = tcpe_pkg::RST_ADC_TOP_X;
    cal_top_y = tcpe_pkg::RST_ADC_TOP_Y;
    cal_width = tcpe_pkg::RST_SCREEN_WIDTH;
    cal_height = tcpe_pkg::RST_SCREEN_HEIGHT;
    cal_mode = tcpe_pkg::RST_ORIENT_MODE;
    cal_touch_valid = 1'b0;

    // Reset settings: swap and flip both axes.
    add_scan(0, 0, 0, 1, 0, CHK_NONE, 0, 0, 0, 0);
    add_scan(0, 0, 0, 0, 0, CHK_EVENT, 239, 319, 0, 0);
    add_scan(1023, 1023, 1023, 0, 0, CHK_EVENT, 0, 0, 1023, 0);
    add_scan(1023, 1023, 1023, 1, 1, CHK_EVENT, 0, 0, 0, 1);
    add_scan(512, 512, 512, 1, 0, CHK_NONE, 0, 0, 0, 0);
    add_scan(400, 600, 300, 0, 1, CHK_NONE, 0, 0, 0, 0);
    add_scan(500, 300, 700, 0, 0, CHK_MODEL, 0, 0, 0, 0);
    add_scan(500, 300, 700, 0, 1, CHK_NONE, 0, 0, 0, 0);
    add_scan(0, 0, 0, 1, 0, CHK_EVENT, 0, 0, 0, 1);
    add_cfg(tcpe_pkg::REG_ORIENT_MODE, tcpe_pkg::CFG_DATA_BITS'(tcpe_pkg::ORIENT_PLAIN));
    add_scan(50, 60, 341, 0, 0, CHK_EVENT, 0, 0, 341, 0);
    add_scan(600, 700, 1, 0, 0, CHK_MODEL, 0, 0, 0, 0);
    add_cfg(tcpe_pkg::REG_ORIENT_MODE, tcpe_pkg::CFG_DATA_BITS'(tcpe_pkg::ORIENT_FLIP_Y));
    add_scan(700, 400, 2, 0, 0, CHK_MODEL, 0, 0, 0, 0);
    add_cfg(tcpe_pkg::REG_OFFSET_X, 1023);
    add_cfg(tcpe_pkg::REG_ADC_TOP_X, 0);
    add_cfg(tcpe_pkg::REG_ADC_TOP_Y, 100);
    add_scan(512, 512, 100, 0, 0, CHK_MODEL, 0, 0, 0, 0);
    add_cfg(tcpe_pkg::REG_ORIENT_MODE, tcpe_pkg::CFG_DATA_BITS'(ORIENT_PLAIN_ALT));
    add_cfg(tcpe_pkg::REG_SCREEN_WIDTH, 0);
    add_cfg(tcpe_pkg::REG_SCREEN_HEIGHT, 2047);
    add_cfg(tcpe_pkg::REG_OFFSET_Y, 0);
    add_cfg(tcpe_pkg::REG_ADC_TOP_Y, 1023);
    add_scan(1023, 1023, 682, 0, 0, CHK_MODEL, 0, 0, 0, 0);
    add_scan(0, 0, 1023, 0, 0, CHK_MODEL, 0, 0, 0, 0);
    add_cfg(tcpe_pkg::REG_OFFSET_X, 0);
    add_cfg(tcpe_pkg::REG_ADC_TOP_X, 1023);
    add_cfg(tcpe_pkg::REG_SCREEN_WIDTH, 1);
    add_cfg(tcpe_pkg::REG_SCREEN_HEIGHT, 1);
    add_cfg(tcpe_pkg::REG_ORIENT_MODE, tcpe_pkg::CFG_DATA_BITS'(tcpe_pkg::ORIENT_SWAP_FLIP));
    add_scan(0, 1023, 3, 0, 0, CHK_MODEL, 0, 0, 0, 0);
    add_scan(7, 9, 4, 1, 0, CHK_EVENT, 0, 0, 0, 1);
    add_cfg(tcpe_pkg::REG_SCREEN_WIDTH, 2047);
    add_cfg(tcpe_pkg::REG_SCREEN_HEIGHT, 2047);
    add_cfg(tcpe_pkg::REG_ADC_TOP_X, 1);
    add_cfg(tcpe_pkg::REG_ADC_TOP_Y, 1);
    add_scan(1, 1, 5, 0, 0, CHK_MODEL, 0, 0, 0, 0);
    add_scan(0, 0, 6, 0, 0, CHK_MODEL, 0, 0, 0, 0);
    add_cfg(tcpe_pkg::REG_SCREEN_WIDTH, 0);
    add_cfg(tcpe_pkg::REG_SCREEN_HEIGHT, 0);
    add_cfg(tcpe_pkg::REG_ADC_TOP_X, 1023);
    add_cfg(tcpe_pkg::REG_ADC_TOP_Y, 1023);
    add_scan(5, 5, 8, 0, 0, CHK_MODEL, 0, 0, 0, 0);
    add_scan(0, 0, 0, 1, 0, CHK_EVENT, 0, 0, 0, 1);

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (stim_rows[i]) begin
      if (stim_rows[i].kind == ROW_CFG) write_reg(stim_rows[i].idx, stim_rows[i].data);
      else send_scan(stim_rows[i].scan, stim_rows[i].chk, stim_rows[i].typed);
    end

    stroke_left = 0;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      regime = phase * 3 / RANDOM_PHASES;
      case (regime)
        0: begin
          send_idle_pct = 11;
          recv_idle_pct = 56;
        end
        1: begin
          send_idle_pct = 56;
          recv_idle_pct = 11;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      random_setup(phase);
      if (phase == 1 || phase == 8) long_hold_req = 1'b1;
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if ($urandom_range(19) == 0) begin
          s.pen_raised = 1'($urandom_range(1));
          s.skip_sample = 1'($urandom_range(1));
        end else if (stroke_left > 0) begin
          s.pen_raised = 1'b0;
          s.skip_sample = ($urandom_range(11) == 0);
          stroke_left--;
        end else begin
          s.pen_raised = 1'b1;
          s.skip_sample = 1'($urandom_range(1));
          stroke_left = $urandom_range(12);
        end
        s.raw_x = pick_sample();
        s.raw_y = pick_sample();
        s.raw_pressure = tcpe_pkg::PRESS_BITS'($urandom_range(0, 1023));
        send_scan(s, CHK_MODEL, '0);
      end
    end

    wait_idle();
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
